FILE: rtl/kct_pkg.sv
// Shared types and constants for the keyed counter table.
// Holds the request/result words, the cell broadcast bus and the control FSM states.
// No dependencies.
`default_nettype none

package kct_pkg;

    // Field widths of the stored entries.
    localparam int KEY_W   = 15;
    localparam int COUNT_W = 31;

    // Largest count; adds saturate here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request kinds. Any other code behaves like a read.
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_GET = 2'd1;
    localparam logic [1:0] KIND_SET = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    // Request word.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] key;
        logic signed [31:0] count_in;
    } kct_in_t;

    // Result word.
    typedef struct packed {
        logic [COUNT_W-1:0] count_out;
        logic [1:0]         status;
    } kct_out_t;

    // Operation broadcast from the controller to every cell.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] val;
        logic               is_add;
        logic               hit_wr;
        logic               ins;
    } kct_bus_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } kct_state_t;

endpackage

`default_nettype wire

FILE: rtl/kct_cell.sv
// One entry of the keyed counter table: valid bit, key, count and match flag.
// Depends on kct_pkg; hands its valid bit to the next cell in the row.
`default_nettype none

module kct_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire kct_pkg::kct_bus_t          bus,
    input  wire logic                       cmp_en,
    input  wire logic                       upd_en,
    input  wire logic                       prev_valid,
    output logic                            valid_o,
    output logic                            hit_o,
    output logic [kct_pkg::COUNT_W-1:0]     rd_o
);
    import kct_pkg::*;

    logic               valid_reg, valid_next;
    logic               hit_reg, hit_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] sat_inc;
    logic [COUNT_W-1:0] new_count;

    // Count this cell would hold after a write on a match.
    always_comb begin
        sat_inc   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        new_count = bus.is_add ? sat_inc : bus.val;
    end

    // Compare while cmp_en is high, write while upd_en is high. Only the cell right
    // after the last occupied one takes an insert, since entries fill in order.
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        hit_next   = hit_reg;
        if (cmp_en) begin
            hit_next = valid_reg && (key_reg == bus.key);
        end
        if (upd_en && bus.hit_wr && hit_reg) begin
            count_next = new_count;
        end
        if (upd_en && bus.ins && prev_valid && !valid_reg) begin
            valid_next = 1'b1;
            key_next   = bus.key;
            count_next = bus.is_add ? COUNT_W'(1) : bus.val;
        end
    end

    // Control bits are reset; key and count are only read behind valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    // Only the matching cell drives a nonzero read value.
    assign valid_o = valid_reg;
    assign hit_o   = hit_reg;
    assign rd_o    = hit_reg ? (bus.hit_wr ? new_count : count_reg) : '0;

endmodule

`default_nettype wire

FILE: rtl/keyed_counter_table.sv
// Top level of the keyed counter table: controller, row of entry cells, result register.
// Depends on kct_pkg and kct_cell.
//
//  Port group     | Dir | Handshake          | Word
//  ---------------+-----+--------------------+-------------------------------
//  s_ (request)   | in  | s_valid / s_ready  | kind, key, count_in
//  m_ (result)    | out | m_valid / m_ready  | count_out, status
//
// Each request passes through ST_CMP, in which every cell compares its key,
// and then ST_UPD, in which the matching or first free cell is written and the
// result word is loaded. A new request is taken in ST_UPD as the result loads.
// Reset clears all valid bits; there is no clearing pass.
// A stalled result holds the controller in its write cycle until it is taken.
`default_nettype none

module keyed_counter_table #(
    parameter int ENTRIES = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire kct_pkg::kct_in_t  s_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kct_pkg::kct_out_t      m_word
);
    import kct_pkg::*;

    kct_state_t state_reg, state_next;
    kct_in_t    req_reg, req_next;
    logic       m_valid_reg, m_valid_next;
    kct_out_t   m_word_reg, m_word_next;

    logic cmp_en, upd_en, out_ok, load;
    logic key_neg, reject, writes, hit_any, full, ins;
    logic [ENTRIES-1:0]              valid_vec, hit_vec;
    logic [ENTRIES-1:0][COUNT_W-1:0] rd_vec;
    logic [COUNT_W-1:0]              rd_or;
    kct_bus_t                        bus;
    kct_out_t                        result;

    // The result register can take a word when empty or draining.
    assign out_ok = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_ok) state_next = s_valid ? ST_CMP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_ready = 1'b0;
        cmp_en  = 1'b0;
        upd_en  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CMP: begin
                cmp_en = 1'b1;
            end
            ST_UPD: begin
                upd_en  = out_ok;
                s_ready = out_ok;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign load     = upd_en;
    assign req_next = (s_valid && s_ready) ? s_word : req_reg;

    // Decode the held request into the cell broadcast.
    always_comb begin
        key_neg = req_reg.key[15];
        reject  = key_neg || ((req_reg.kind == KIND_SET) && req_reg.count_in[31]);
        writes  = !reject && ((req_reg.kind == KIND_ADD) || (req_reg.kind == KIND_SET));
        ins     = writes && !hit_any;
        bus.key    = req_reg.key[KEY_W-1:0];
        bus.val    = req_reg.count_in[COUNT_W-1:0];
        bus.is_add = (req_reg.kind == KIND_ADD);
        bus.hit_wr = writes;
        bus.ins    = ins;
    end

    // Row of cells; each one sees whether its left neighbor is occupied.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic prev_valid;
        if (i == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = valid_vec[i-1];
        end
        kct_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .bus        (bus),
            .cmp_en     (cmp_en),
            .upd_en     (upd_en),
            .prev_valid (prev_valid),
            .valid_o    (valid_vec[i]),
            .hit_o      (hit_vec[i]),
            .rd_o       (rd_vec[i])
        );
    end

    // Keys are unique, so at most one cell drives its read value.
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            rd_or = rd_or | rd_vec[i];
        end
    end

    assign hit_any = |hit_vec;
    assign full    = valid_vec[ENTRIES-1];

    // Result word.
    always_comb begin
        result.count_out = '0;
        result.status    = STATUS_DONE;
        if (reject) begin
            result.status = STATUS_REJECT;
        end else if (hit_any) begin
            result.count_out = rd_or;
        end else if (ins) begin
            if (full) begin
                result.status = STATUS_FULL;
            end else begin
                result.count_out = bus.is_add ? COUNT_W'(1) : bus.val;
            end
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_word_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // At most one cell may match a key.
    a_hit_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot0(hit_vec))
        else $error("more than one cell matched the key");

    // Entries fill from the lowest index up with no gaps.
    a_valid_therm: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
        else $error("occupied entries are not contiguous");

    // The table never loses entries.
    a_no_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(valid_vec) >= $past($countones(valid_vec))))
        else $error("an occupied entry was dropped");

    // A full status is only given when every entry is occupied.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (result.status == STATUS_FULL)) |-> (valid_vec == '1))
        else $error("full status reported with free entries");

endmodule

`default_nettype wire
